@@ rtl/best_fit_heap_allocator_macros.svh @@
// Assertion macros shared by the checker of the best-fit heap allocator.
// Each macro expands to one labeled concurrent assertion on clk, off during reset.
`ifndef BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFHA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfha check failed");

// next-cycle implication
`define BFHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfha check failed");

`endif

@@ rtl/bfha_pkg.sv @@
// Types, codes and helpers of the best-fit heap allocator.
// Used by the top level and its checker; depends on nothing.
`default_nettype none
package bfha_pkg;

	localparam int FREE_ENTRIES_DEF = 64;
	localparam int HEADER_BYTES_DEF = 24;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_EXH  = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] req_size;
		logic [31:0] req_address;
	} req_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [1:0]  status;
	} rsp_t;

	// a + b + h, saturated to 32 bits
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] h);
		logic [33:0] sum;
		sum = {2'b00, a} + {2'b00, b} + {2'b00, h};
		return (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/best_fit_heap_allocator.sv @@
// Best-fit heap allocator: sorted free table in one synchronous RAM plus a break pointer.
// A zero-size allocate, a free of address 0 or a free into a full table goes straight to the
// result state; otherwise the table is scanned and a decision made, a free then tries a merge,
// and the table is shifted when an insert or removal moves entries. Throughput: one item at a time.
// Reset clears the entry count, sets the break to 0 and the limit to all ones; RAM is not cleared.
`default_nettype none
module best_fit_heap_allocator
	import bfha_pkg::*;
#(
	parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire req_t        in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output rsp_t             out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int IW = $clog2(FREE_ENTRIES);
	localparam int CW = $clog2(FREE_ENTRIES + 1);
	localparam logic [33:0] HDR = 34'(HEADER_BYTES);
	localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
	localparam logic [CW-1:0] FULL = CW'(FREE_ENTRIES);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_DECIDE   = 3'd2;
	localparam logic [2:0] S_MERGE    = 3'd3;
	localparam logic [2:0] S_SHIFT_DN = 3'd4;
	localparam logic [2:0] S_SHIFT_UP = 3'd5;
	localparam logic [2:0] S_OUT      = 3'd6;

	logic [63:0] mem [FREE_ENTRIES];
	logic [63:0] rdata_s1;
	logic        re, we;
	logic [IW-1:0] ra, wa;
	logic [63:0] wd;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [31:0]   limit_q, brk_q;
	logic [CW-1:0] count_q, k_q, pos_q;
	logic          dv_s1;
	logic [IW-1:0] didx_s1;
	logic          found_q, exact_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   best_addr_q, best_size_q;
	logic [31:0]   prev_addr_q, prev_size_q;
	logic          next_valid_q;
	logic [31:0]   next_addr_q, next_size_q;
	logic          mnext_q, mprev_q;
	logic [31:0]   msize_q;
	rsp_t          res_q, out_q;
	logic          out_valid_q;

	logic [31:0]   blk, rd_addr, rd_size;
	logic [33:0]   need, nb;
	logic [CW-1:0] km1, pos_m1;
	logic          mnext_d, mprev_d;

	assign blk     = req_q.req_address - HDR32;
	assign need    = {2'b00, req_q.req_size} + HDR;
	assign nb      = {2'b00, brk_q} + need;
	assign rd_addr = rdata_s1[63:32];
	assign rd_size = rdata_s1[31:0];
	assign km1     = k_q - 1'b1;
	assign pos_m1  = pos_q - 1'b1;
	assign mnext_d = next_valid_q &&
		({2'b00, blk} + {2'b00, req_q.req_size} + HDR == {2'b00, next_addr_q});
	assign mprev_d = (pos_q != '0) &&
		({2'b00, prev_addr_q} + {2'b00, prev_size_q} + HDR == {2'b00, blk});

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rdata_s1 <= mem[ra];
	end

	always_comb begin
		re = 1'b0;
		ra = k_q[IW-1:0];
		we = 1'b0;
		wa = pos_q[IW-1:0];
		wd = {blk, req_q.req_size};
		case (state_q)
			S_SCAN: begin
				re = (k_q < count_q);
			end
			S_DECIDE: begin
				// split: remainder takes the entry's place
				if (req_q.opcode == OP_ALLOC && found_q && !exact_q) begin
					we = 1'b1;
					wa = best_idx_q;
					wd = {32'(best_addr_q + need[31:0]), 32'({2'b00, best_size_q} - need)};
				end
			end
			S_MERGE: begin
				if (mprev_q) begin
					we = 1'b1;
					wa = pos_m1[IW-1:0];
					wd = {prev_addr_q, sat_add(prev_size_q, msize_q, HDR32)};
				end else if (mnext_q) begin
					we = 1'b1;
					wd = {blk, msize_q};
				end
			end
			S_SHIFT_DN: begin
				re = (k_q < count_q);
				we = dv_s1;
				wa = didx_s1 - 1'b1;
				wd = rdata_s1;
			end
			S_SHIFT_UP: begin
				re = (k_q > pos_q);
				ra = km1[IW-1:0];
				if (dv_s1) begin
					we = 1'b1;
					wa = didx_s1 + 1'b1;
					wd = rdata_s1;
				end else if (k_q <= pos_q) begin
					// open slot reached: place the freed block
					we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= 32'hFFFF_FFFF;
			brk_q        <= '0;
			count_q      <= '0;
			k_q          <= '0;
			pos_q        <= '0;
			dv_s1        <= 1'b0;
			found_q      <= 1'b0;
			exact_q      <= 1'b0;
			next_valid_q <= 1'b0;
			mnext_q      <= 1'b0;
			mprev_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_HEAP_BASE:  brk_q <= cfg_data;
					CFG_HEAP_LIMIT: limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q        <= in_data;
						k_q          <= '0;
						pos_q        <= '0;
						dv_s1        <= 1'b0;
						found_q      <= 1'b0;
						exact_q      <= 1'b0;
						next_valid_q <= 1'b0;
						res_q        <= '{result_address: '0, status: ST_OK};
						if (in_data.opcode == OP_ALLOC && in_data.req_size == '0) begin
							res_q.status <= ST_ZERO;
							state_q <= S_OUT;
						end else if (in_data.opcode == OP_FREE && in_data.req_address == '0) begin
							state_q <= S_OUT;
						end else if (in_data.opcode == OP_FREE && count_q >= FULL) begin
							res_q.status <= ST_FULL;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					dv_s1   <= (k_q < count_q);
					didx_s1 <= k_q[IW-1:0];
					if (k_q < count_q)
						k_q <= k_q + 1'b1;
					if (dv_s1) begin
						if (req_q.opcode == OP_ALLOC) begin
							if (rd_size == req_q.req_size) begin
								found_q     <= 1'b1;
								exact_q     <= 1'b1;
								best_idx_q  <= didx_s1;
								best_addr_q <= rd_addr;
								dv_s1       <= 1'b0;
								state_q     <= S_DECIDE;
							end else if ({2'b00, rd_size} > need &&
								(!found_q || best_size_q > rd_size)) begin
								found_q     <= 1'b1;
								best_idx_q  <= didx_s1;
								best_addr_q <= rd_addr;
								best_size_q <= rd_size;
							end
						end else begin
							if (rd_addr < blk) begin
								prev_addr_q <= rd_addr;
								prev_size_q <= rd_size;
								pos_q       <= CW'(didx_s1) + 1'b1;
							end else begin
								next_valid_q <= 1'b1;
								next_addr_q  <= rd_addr;
								next_size_q  <= rd_size;
								dv_s1        <= 1'b0;
								state_q      <= S_DECIDE;
							end
						end
					end else if (k_q >= count_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (req_q.opcode == OP_ALLOC) begin
						if (!found_q) begin
							if (nb > {2'b00, limit_q}) begin
								res_q.status <= ST_EXH;
							end else begin
								res_q.result_address <= brk_q + HDR32;
								brk_q <= nb[31:0];
							end
							state_q <= S_OUT;
						end else begin
							res_q.result_address <= best_addr_q + HDR32;
							if (exact_q) begin
								k_q     <= CW'(best_idx_q) + 1'b1;
								dv_s1   <= 1'b0;
								state_q <= S_SHIFT_DN;
							end else begin
								state_q <= S_OUT;
							end
						end
					end else begin
						mnext_q <= mnext_d;
						mprev_q <= mprev_d;
						msize_q <= mnext_d ? sat_add(req_q.req_size, next_size_q, HDR32)
							: req_q.req_size;
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					dv_s1 <= 1'b0;
					if (!mnext_q && !mprev_q) begin
						k_q     <= count_q;
						state_q <= S_SHIFT_UP;
					end else if (mnext_q && mprev_q) begin
						// drop the absorbed next entry
						k_q     <= pos_q + 1'b1;
						state_q <= S_SHIFT_DN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SHIFT_DN: begin
					dv_s1   <= (k_q < count_q);
					didx_s1 <= k_q[IW-1:0];
					if (k_q < count_q)
						k_q <= k_q + 1'b1;
					if (!dv_s1 && k_q >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_SHIFT_UP: begin
					dv_s1   <= (k_q > pos_q);
					didx_s1 <= km1[IW-1:0];
					if (k_q > pos_q)
						k_q <= km1;
					if (!dv_s1 && k_q <= pos_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/bfha_checker.sv @@
// Port-level checks of the best-fit heap allocator, bound to the top level.
// Depends on bfha_pkg and best_fit_heap_allocator_macros.svh.
`default_nettype none
`include "best_fit_heap_allocator_macros.svh"
module bfha_checker
	import bfha_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_data
);

	// one item in flight: no second accept right after one
	`BFHA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// a failed result never carries an address
	`BFHA_ASSERT_NOW(a_fail_no_addr, out_valid && out_data.status != ST_OK,
		out_data.result_address == '0)
	// hold a result unchanged until it is taken
	`BFHA_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_data))
	// a result appears as the block returns to idle
	`BFHA_ASSERT_NOW(a_idle_on_result, $rose(out_valid), in_ready)

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (.*);
`default_nettype wire
